// ----- hw/rtl/hdr_bracket_merge_assert.svh -----
// assertion macros shared by the bracket merge rtl
`ifndef HDR_BRACKET_MERGE_ASSERT_SVH
`define HDR_BRACKET_MERGE_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define HBM_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HBM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/hbm_pkg.sv -----
// shared constants and types of the bracket merge pipeline
package hbm_pkg;

   localparam int BRACKETS      = 4;
   localparam int SAMPLE_FIELDS = 4;
   localparam int LANES         = (BRACKETS < SAMPLE_FIELDS) ? BRACKETS : SAMPLE_FIELDS;

   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = 24;
   localparam int FRAC_W   = 16;
   localparam int CH_W     = 2;
   localparam int CNT_W    = 3;
   localparam int CSR_IDX_W = 2;

   // triangle weight, worked in units of 1/(65536*200)
   localparam int TRI_SLOPE_W = 25;
   localparam int TRI_D_W     = 26;
   localparam int TRI_MAG_W   = 25;
   localparam int TRI_PEAK_W  = 24;
   localparam logic [TRI_SLOPE_W-1:0]   TRI_SLOPE = 25'd380;
   localparam logic signed [TRI_D_W-1:0] TRI_BIAS = 26'sd7798784;
   localparam logic [TRI_PEAK_W-1:0]    TRI_PEAK  = 24'd13107200;
   localparam logic [TRI_PEAK_W-1:0]    TRI_ROUND = 24'd100;
   localparam int TRI_PRE_SHIFT = 3;

   // divide by 25 through a reciprocal, exact below 2^26/11
   localparam int V_W          = 21;
   localparam int RECIP_W      = 22;
   localparam int RECIP_SHIFT  = 26;
   localparam logic [RECIP_W-1:0] RECIP = 22'd2684355;

   localparam int W_W      = FRAC_W + 1;
   localparam int PROD_W   = SAMPLE_W + GAIN_W;
   localparam int TERM_W   = PROD_W + W_W;
   localparam int WSUM_W   = W_W + $clog2(LANES);
   localparam int NUM_W    = TERM_W + $clog2(LANES) + 1;
   localparam int NH_W     = NUM_W - FRAC_W;
   localparam int Q_W      = GAIN_W;
   localparam int REM_W    = NH_W - Q_W;

   localparam logic [GAIN_W-1:0] UNITY_GAIN = 24'd65536;
   localparam logic [Q_W-1:0]    RESULT_MAX = {Q_W{1'b1}};
   localparam logic [CH_W-1:0]   CH_ALPHA   = 2'd3;
   localparam logic [CNT_W-1:0]  CNT_LANES  = CNT_W'(LANES);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACTIVE     = 2'd0,
      CSR_GAIN_ONE   = 2'd1,
      CSR_GAIN_TWO   = 2'd2,
      CSR_GAIN_THREE = 2'd3
   } csr_index_type;

   // per-beat control that rides beside the payload
   typedef struct packed {
      logic valid;
      logic alpha;
      logic empty;
      logic sat;
   } ctl_type;

endpackage

// ----- hw/rtl/hdr_bracket_merge.sv -----
// top level of the hdr bracket merge pipeline
//
// Input stream req_*: one beat carries one color component from each of the
// four exposure brackets plus the component index. Output stream rsp_*: one
// beat per input beat, in order, with the merged Q8.16 value and a flag for
// a beat whose active weights were all zero. Alpha beats give 1.0.
// csr_* writes the bracket count and the gains of brackets one to three.
// An accepted input beat reaches rsp_tvalid through three lane
// stages (weight, gain product, weighted term), one sum stage, one divider
// entry stage, six divider stages of four quotient bits each and one output
// register. Throughput is one beat per cycle; the divider stages set the
// depth. All stages move together; when rsp_tready is low while a result
// waits, req_tready drops and every stage holds its beat, and the whole
// pipeline moves again once the output register is free. Reset is
// synchronous: it empties the pipeline and loads a count of four brackets
// and unity gains.
`include "hdr_bracket_merge_assert.svh"

module hdr_bracket_merge (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [63:0] req_tdata,  // sample_zero, sample_one, sample_two, sample_three
   input  logic [hbm_pkg::CH_W-1:0]        req_tuser,   // channel_index
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [23:0]                     rsp_tdata,   // merged_value
   output logic [0:0]                      rsp_tuser,   // no_weight
   input  logic                            csr_we,
   input  logic [hbm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hbm_pkg::GAIN_W-1:0]      csr_wdata
);

   localparam int SUM_STAGES = 4;

   logic [hbm_pkg::CNT_W-1:0]  active_ff;
   logic [hbm_pkg::GAIN_W-1:0] gain_ff [1:hbm_pkg::SAMPLE_FIELDS-1];
   logic [hbm_pkg::GAIN_W-1:0] lane_gain [0:hbm_pkg::LANES-1];
   logic [hbm_pkg::CNT_W-1:0]  count;
   logic                       adv;

   hbm_pkg::ctl_type           ctl_in;
   hbm_pkg::ctl_type           ctl_ff [0:SUM_STAGES-1];
   logic [hbm_pkg::TERM_W-1:0] term   [0:hbm_pkg::LANES-1];
   logic [hbm_pkg::W_W-1:0]    weight [0:hbm_pkg::LANES-1];

   logic [hbm_pkg::NUM_W-1:0]  num_in;
   logic [hbm_pkg::WSUM_W-1:0] wsum_in, wsum_ff;
   logic [hbm_pkg::NH_W-1:0]   nh_ff;

   hbm_pkg::ctl_type           div_ctl;
   logic [hbm_pkg::Q_W-1:0]    div_quo;

   logic                       rsp_valid_ff;
   logic [hbm_pkg::Q_W-1:0]    rsp_data_in, rsp_data_ff;
   logic                       rsp_flag_in, rsp_flag_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= hbm_pkg::CNT_W'(4);
         for (int b = 1; b < hbm_pkg::SAMPLE_FIELDS; b++) begin
            gain_ff[b] <= hbm_pkg::UNITY_GAIN;
         end
      end else if (csr_we) begin
         unique case (hbm_pkg::csr_index_type'(csr_index))
            hbm_pkg::CSR_ACTIVE:     active_ff  <= csr_wdata[hbm_pkg::CNT_W-1:0];
            hbm_pkg::CSR_GAIN_ONE:   gain_ff[1] <= csr_wdata;
            hbm_pkg::CSR_GAIN_TWO:   gain_ff[2] <= csr_wdata;
            hbm_pkg::CSR_GAIN_THREE: gain_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      count = active_ff;
      if (count == '0) begin
         count = hbm_pkg::CNT_W'(1);
      end
      if (count > hbm_pkg::CNT_LANES) begin
         count = hbm_pkg::CNT_LANES;
      end
   end

   // bracket zero runs at unity gain
   always_comb begin
      lane_gain[0] = hbm_pkg::UNITY_GAIN;
      for (int b = 1; b < hbm_pkg::LANES; b++) begin
         lane_gain[b] = gain_ff[b];
      end
   end

   // global stage enable: move whenever the output register can take a beat
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   always_comb begin
      ctl_in       = '0;
      ctl_in.valid = req_tvalid;
      ctl_in.alpha = (req_tuser == hbm_pkg::CH_ALPHA);
   end

   for (genvar b = 0; b < hbm_pkg::LANES; b++) begin : g_lane
      hbm_lane u_lane (
         .clock  (clock),
         .adv    (adv),
         .sample (req_tdata[b*hbm_pkg::SAMPLE_W +: hbm_pkg::SAMPLE_W]),
         .gain   (lane_gain[b]),
         .active (hbm_pkg::CNT_W'(b) < count),
         .term   (term[b]),
         .weight (weight[b])
      );
   end

   // control beside the three lane stages and the sum stage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SUM_STAGES; s++) begin
            ctl_ff[s] <= '0;
         end
      end else if (adv) begin
         ctl_ff[0] <= ctl_in;
         for (int s = 1; s < SUM_STAGES; s++) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
      end
   end

   // sum stage: numerator plus half the denominator, then drop the fraction
   always_comb begin
      wsum_in = '0;
      num_in  = '0;
      for (int b = 0; b < hbm_pkg::LANES; b++) begin
         wsum_in = wsum_in + hbm_pkg::WSUM_W'(weight[b]);
         num_in  = num_in + hbm_pkg::NUM_W'(term[b]);
      end
      num_in = num_in + (hbm_pkg::NUM_W'(wsum_in) << (hbm_pkg::FRAC_W - 1));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         wsum_ff <= wsum_in;
         nh_ff   <= num_in[hbm_pkg::NUM_W-1:hbm_pkg::FRAC_W];
      end
   end

   hbm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .ctl_i    (ctl_ff[SUM_STAGES-1]),
      .dividend (nh_ff),
      .divisor  (wsum_ff),
      .ctl_o    (div_ctl),
      .quotient (div_quo)
   );

   // result select and output register
   always_comb begin
      rsp_flag_in = 1'b0;
      if (div_ctl.alpha) begin
         rsp_data_in = hbm_pkg::UNITY_GAIN;
      end else if (div_ctl.empty) begin
         rsp_data_in = '0;
         rsp_flag_in = 1'b1;
      end else if (div_ctl.sat) begin
         rsp_data_in = hbm_pkg::RESULT_MAX;
      end else begin
         rsp_data_in = div_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= div_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
         rsp_flag_ff <= rsp_flag_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_flag_ff;

   `HBM_ASSERT_IMPLIES(a_empty_after_reset, $past(reset), !rsp_tvalid,
      "output beat right after reset")
   `HBM_ASSERT_NEXT(a_stall_holds, !adv, $stable(ctl_ff[SUM_STAGES-1]),
      "sum stage moved during a stall")
   `HBM_ASSERT_IMPLIES(a_flag_zero_value, rsp_tvalid && rsp_tuser[0],
      rsp_tdata == '0, "no-weight beat with nonzero value")

endmodule

// ----- hw/rtl/hbm_lane.sv -----
// one bracket lane: triangle weight, gain product and weighted term over three stages
module hbm_lane (
   input  logic                         clock,
   input  logic                         adv,
   input  logic [hbm_pkg::SAMPLE_W-1:0] sample,
   input  logic [hbm_pkg::GAIN_W-1:0]   gain,
   input  logic                         active,
   output logic [hbm_pkg::TERM_W-1:0]   term,
   output logic [hbm_pkg::W_W-1:0]      weight
);

   logic [hbm_pkg::TRI_SLOPE_W-1:0]          slope_x;
   logic signed [hbm_pkg::TRI_D_W-1:0]       offset;
   logic [hbm_pkg::TRI_MAG_W-1:0]            mag;
   logic [hbm_pkg::TRI_MAG_W:0]              mag2;
   logic [hbm_pkg::TRI_PEAK_W-1:0]           peak_sum;
   logic [hbm_pkg::V_W-1:0]                  v_in, v_ff;
   logic [hbm_pkg::SAMPLE_W-1:0]             x_ff;
   logic [hbm_pkg::V_W+hbm_pkg::RECIP_W-1:0] recip_prod;
   logic [hbm_pkg::W_W-1:0]                  w_in, w2_ff, w3_ff;
   logic [hbm_pkg::PROD_W-1:0]               p_in, p_ff;
   logic [hbm_pkg::TERM_W-1:0]               term_in, term_ff;

   // stage one: exact weight numerator, pre-scaled by 1/8
   always_comb begin
      slope_x  = hbm_pkg::TRI_SLOPE_W'(sample) * hbm_pkg::TRI_SLOPE;
      offset   = hbm_pkg::TRI_BIAS - $signed({1'b0, slope_x});
      mag      = offset[hbm_pkg::TRI_D_W-1] ? hbm_pkg::TRI_MAG_W'(-offset)
                                             : hbm_pkg::TRI_MAG_W'(offset);
      mag2     = {mag, 1'b0};
      peak_sum = '0;
      v_in     = '0;
      if (mag2 < (hbm_pkg::TRI_MAG_W+1)'(hbm_pkg::TRI_PEAK)) begin
         peak_sum = hbm_pkg::TRI_PEAK - hbm_pkg::TRI_PEAK_W'(mag2) + hbm_pkg::TRI_ROUND;
         v_in     = hbm_pkg::V_W'(peak_sum >> hbm_pkg::TRI_PRE_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         v_ff <= v_in;
         x_ff <= sample;
      end
   end

   // stage two: divide by 25, sample times gain
   always_comb begin
      recip_prod = (hbm_pkg::V_W+hbm_pkg::RECIP_W)'(v_ff) * hbm_pkg::RECIP;
      w_in       = active ? recip_prod[hbm_pkg::RECIP_SHIFT +: hbm_pkg::W_W] : '0;
      p_in       = hbm_pkg::PROD_W'(x_ff) * hbm_pkg::PROD_W'(gain);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         w2_ff <= w_in;
         p_ff  <= p_in;
      end
   end

   // stage three: weighted term
   assign term_in = hbm_pkg::TERM_W'(p_ff) * hbm_pkg::TERM_W'(w2_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         term_ff <= term_in;
         w3_ff   <= w2_ff;
      end
   end

   assign term   = term_ff;
   assign weight = w3_ff;

endmodule

// ----- hw/rtl/hbm_divider.sv -----
// pipelined restoring divider, four quotient bits per stage, with overflow detect
`include "hdr_bracket_merge_assert.svh"

module hbm_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  hbm_pkg::ctl_type            ctl_i,
   input  logic [hbm_pkg::NH_W-1:0]    dividend,
   input  logic [hbm_pkg::WSUM_W-1:0]  divisor,
   output hbm_pkg::ctl_type            ctl_o,
   output logic [hbm_pkg::Q_W-1:0]     quotient
);

   localparam int STEP_BITS  = 4;
   localparam int DIV_STAGES = hbm_pkg::Q_W / STEP_BITS;

   typedef struct packed {
      logic [hbm_pkg::REM_W-1:0]  rem;
      logic [hbm_pkg::Q_W-1:0]    low;
      logic [hbm_pkg::Q_W-1:0]    quo;
      logic [hbm_pkg::WSUM_W-1:0] dsor;
   } div_type;

   function automatic div_type div_step(div_type s);
      div_type                   r;
      logic [hbm_pkg::REM_W:0]   t;
      r = s;
      for (int i = 0; i < STEP_BITS; i++) begin
         t     = {r.rem, r.low[hbm_pkg::Q_W-1]};
         r.low = {r.low[hbm_pkg::Q_W-2:0], 1'b0};
         if (t >= (hbm_pkg::REM_W+1)'(r.dsor)) begin
            t     = t - (hbm_pkg::REM_W+1)'(r.dsor);
            r.quo = {r.quo[hbm_pkg::Q_W-2:0], 1'b1};
         end else begin
            r.quo = {r.quo[hbm_pkg::Q_W-2:0], 1'b0};
         end
         r.rem = t[hbm_pkg::REM_W-1:0];
      end
      return r;
   endfunction

   hbm_pkg::ctl_type ctl_ff [0:DIV_STAGES];
   div_type          dv_ff  [0:DIV_STAGES];
   hbm_pkg::ctl_type ctl0_in;
   div_type          dv0_in;

   // entry stage: split dividend, flag overflow and empty divisor
   always_comb begin
      dv0_in.rem   = dividend[hbm_pkg::NH_W-1:hbm_pkg::Q_W];
      dv0_in.low   = dividend[hbm_pkg::Q_W-1:0];
      dv0_in.quo   = '0;
      dv0_in.dsor  = divisor;
      ctl0_in      = ctl_i;
      ctl0_in.empty = (divisor == '0);
      ctl0_in.sat   = (dv0_in.rem >= hbm_pkg::REM_W'(divisor));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (adv) begin
         ctl_ff[0] <= ctl0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_ff[0] <= dv0_in;
      end
   end

   for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_step
      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k] <= '0;
         end else if (adv) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_ff[k] <= div_step(dv_ff[k-1]);
         end
      end
   end

   assign ctl_o    = ctl_ff[DIV_STAGES];
   assign quotient = dv_ff[DIV_STAGES].quo;

   `HBM_ASSERT_IMPLIES(a_rem_below_dsor,
      ctl_ff[DIV_STAGES].valid && !ctl_ff[DIV_STAGES].sat,
      dv_ff[DIV_STAGES].rem < hbm_pkg::REM_W'(dv_ff[DIV_STAGES].dsor),
      "remainder not below divisor")
   `HBM_ASSERT_IMPLIES(a_empty_is_sat, ctl_ff[0].valid && ctl_ff[0].empty,
      ctl_ff[0].sat, "zero divisor not caught as overflow")
   `HBM_ASSERT_IMPLIES(a_shift_on_adv, $past(adv) && !$past(reset),
      ctl_ff[1] == $past(ctl_ff[0]), "divider control did not shift")

endmodule

// ----- test/tb_top.sv -----
// testbench for hdr_bracket_merge: directed rows, then random beats checked against a predictor
`timescale 1ns / 100ps

module tb_top;

   localparam int DIRECTED_ROWS = 26;
   localparam int PHASES        = 8;
   localparam int PHASE_BEATS   = 240;
   localparam int LONG_HOLD     = 300;
   localparam int STALL_LIMIT   = 4000;
   localparam int DRAIN_CYCLES  = 24;

   typedef struct packed {
      logic [23:0] value;
      logic        flag;
   } merge_result_type;

   typedef struct packed {
      logic             typed;
      merge_result_type result;
   } beat_plan_type;

   typedef struct packed {
      logic                   is_csr;
      hbm_pkg::csr_index_type idx;
      logic [23:0]            wval;
      logic [63:0]            samples;
      logic [1:0]             ch;
      logic                   typed;
      logic [23:0]            value;
      logic                   flag;
   } step_row_type;

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [63:0]                   req_tdata  = '0;
   logic [hbm_pkg::CH_W-1:0]      req_tuser  = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [23:0]                   rsp_tdata;
   logic [0:0]                    rsp_tuser;
   logic                          csr_we     = 1'b0;
   logic [hbm_pkg::CSR_IDX_W-1:0] csr_index  = '0;
   logic [hbm_pkg::GAIN_W-1:0]    csr_wdata  = '0;

   // register copy used by the predictor
   logic [2:0]  cfg_count = 3'd4;
   logic [23:0] gain_cfg [1:3] = '{hbm_pkg::UNITY_GAIN, hbm_pkg::UNITY_GAIN,
                                   hbm_pkg::UNITY_GAIN};

   merge_result_type merged_expect_q [$];
   beat_plan_type    beat_plan_q [$];
   int               beats_sent   = 0;
   int               results_seen = 0;
   int               error_count  = 0;
   int               idle_cycles  = 0;
   int               stall_pct    = 0;
   int               hold_asked   = 0;
   int               hold_taken   = 0;
   int               hold_left    = 0;

   step_row_type directed_rows [DIRECTED_ROWS] = '{
      '{1'b0, hbm_pkg::CSR_ACTIVE, 24'd0, {4{16'd0}}, 2'd0, 1'b1, 24'd0, 1'b1},
      '{1'b0, hbm_pkg::CSR_ACTIVE, 24'd0, {4{16'hFFFF}}, 2'd1, 1'b1, 24'd0, 1'b1},
      '{1'b0, hbm_pkg::CSR_ACTIVE, 24'd0, {4{16'd20525}}, 2'd2, 1'b1, 24'd20525, 1'b0},
      '{1'b0, hbm_pkg::CSR_ACTIVE, 24'd0, {4{16'hFFFF}}, 2'd3, 1'b1, 24'd65536, 1'b0},
      '{1'b0, hbm_pkg::CSR_ACTIVE, 24'd0, {4{16'd0}}, 2'd3, 1'b1, 24'd65536, 1'b0},
      '{1'b0, hbm_pkg::CSR_ACTIVE, 24'd0, {16'hDEF0, 16'h9ABC, 16'h5678, 16'h1234}, 2'd0,
        1'b0, 24'd0, 1'b0},
      '{1'b0, hbm_pkg::CSR_ACTIVE, 24'd0, {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}, 2'd1,
        1'b0, 24'd0, 1'b0},
      '{1'b0, hbm_pkg::CSR_ACTIVE, 24'd0, {16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}, 2'd2,
        1'b0, 24'd0, 1'b0},
      '{1'b0, hbm_pkg::CSR_ACTIVE, 24'd0, {16'd20000, 16'd0, 16'hFFFF, 16'd0}, 2'd0,
        1'b1, 24'd20000, 1'b0},
      '{1'b0, hbm_pkg::CSR_ACTIVE, 24'd0, {16'd3276, 16'd3277, 16'd3276, 16'd3277}, 2'd1,
        1'b0, 24'd0, 1'b0},
      '{1'b0, hbm_pkg::CSR_ACTIVE, 24'd0,
        {16'd37770, 16'd37769, 16'd37770, 16'd37769}, 2'd2, 1'b0, 24'd0, 1'b0},
      '{1'b1, hbm_pkg::CSR_ACTIVE, 24'd0, 64'd0, 2'd0, 1'b0, 24'd0, 1'b0},
      '{1'b0, hbm_pkg::CSR_ACTIVE, 24'd0,
        {16'd30000, 16'd30000, 16'd30000, 16'd20525}, 2'd0, 1'b1, 24'd20525, 1'b0},
      '{1'b0, hbm_pkg::CSR_ACTIVE, 24'd0, {16'd20000, 16'd20000, 16'd20000, 16'd0}, 2'd1,
        1'b1, 24'd0, 1'b1},
      '{1'b1, hbm_pkg::CSR_ACTIVE, 24'd7, 64'd0, 2'd0, 1'b0, 24'd0, 1'b0},
      '{1'b0, hbm_pkg::CSR_ACTIVE, 24'd0, {4{16'd20525}}, 2'd2, 1'b1, 24'd20525, 1'b0},
      '{1'b1, hbm_pkg::CSR_ACTIVE, 24'd5, 64'd0, 2'd0, 1'b0, 24'd0, 1'b0},
      '{1'b0, hbm_pkg::CSR_ACTIVE, 24'd0, {16'hDEF0, 16'h9ABC, 16'h5678, 16'h1234}, 2'd1,
        1'b0, 24'd0, 1'b0},
      '{1'b1, hbm_pkg::CSR_ACTIVE, 24'd2, 64'd0, 2'd0, 1'b0, 24'd0, 1'b0},
      '{1'b1, hbm_pkg::CSR_GAIN_ONE, 24'hFFFFFF, 64'd0, 2'd0, 1'b0, 24'd0, 1'b0},
      '{1'b0, hbm_pkg::CSR_ACTIVE, 24'd0, {16'hFFFF, 16'hFFFF, 16'd30000, 16'd20525}, 2'd0,
        1'b0, 24'd0, 1'b0},
      '{1'b1, hbm_pkg::CSR_GAIN_ONE, 24'd0, 64'd0, 2'd0, 1'b0, 24'd0, 1'b0},
      '{1'b1, hbm_pkg::CSR_ACTIVE, 24'd4, 64'd0, 2'd0, 1'b0, 24'd0, 1'b0},
      '{1'b1, hbm_pkg::CSR_GAIN_TWO, 24'd0, 64'd0, 2'd0, 1'b0, 24'd0, 1'b0},
      '{1'b1, hbm_pkg::CSR_GAIN_THREE, 24'hFFFFFF, 64'd0, 2'd0, 1'b0, 24'd0, 1'b0},
      '{1'b0, hbm_pkg::CSR_ACTIVE, 24'd0,
        {16'd25000, 16'd20000, 16'd15000, 16'd10000}, 2'd2, 1'b0, 24'd0, 1'b0}
   };

   hdr_bracket_merge i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // triangle weight in q1.16, formed exactly in units of 1/(65536*200)
   function automatic logic [16:0] tri_weight_q16(input logic [15:0] x);
      longint t;
      longint d;
      longint w;
      t = 19 * (20 * longint'(x) - 65536);
      d = 6553600 - t;
      if (d < 0) d = -d;
      w = 13107200 - 2 * d;
      if (w <= 0) return 17'd0;
      return 17'((w + 100) / 200);
   endfunction

   function automatic merge_result_type merge_predict(input logic [63:0] samples,
                                                      input logic [1:0] ch);
      merge_result_type r;
      longint unsigned  num;
      longint unsigned  wsum;
      longint unsigned  den;
      longint unsigned  q;
      longint unsigned  x;
      longint unsigned  w;
      longint unsigned  g;
      int               n;
      if (ch == hbm_pkg::CH_ALPHA) begin
         r.value = hbm_pkg::UNITY_GAIN;
         r.flag  = 1'b0;
         return r;
      end
      n = int'(cfg_count);
      if (n < 1) n = 1;
      if (n > hbm_pkg::LANES) n = hbm_pkg::LANES;
      num  = 0;
      wsum = 0;
      for (int b = 0; b < n; b++) begin
         x = longint'(samples[16*b +: 16]);
         w = longint'(tri_weight_q16(samples[16*b +: 16]));
         g = (b == 0) ? longint'(hbm_pkg::UNITY_GAIN) : longint'(gain_cfg[b]);
         num  += x * g * w;
         wsum += w;
      end
      if (wsum == 0) begin
         r.value = 24'd0;
         r.flag  = 1'b1;
         return r;
      end
      den = wsum << 16;
      q = (num + den / 2) / den;
      if (q > longint'(hbm_pkg::RESULT_MAX)) q = longint'(hbm_pkg::RESULT_MAX);
      r.value = q[23:0];
      r.flag  = 1'b0;
      return r;
   endfunction

   function automatic logic [15:0] pick_sample(input bit dead);
      int unsigned r;
      if (dead) begin
         if ($urandom_range(1) == 0) return 16'($urandom_range(3276));
         return 16'($urandom_range(65535, 37770));
      end
      r = $urandom_range(9);
      case (r) inside
         0: return 16'd0;
         1: return 16'hFFFF;
         [2:4]: return 16'($urandom_range(37769, 3277));
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [23:0] pick_gain();
      case ($urandom_range(3))
         0: return 24'($urandom());
         1: return 24'd1 << $urandom_range(23);
         2: return ($urandom_range(1) == 0) ? 24'd0 : 24'hFFFFFF;
         default: return 24'($urandom());
      endcase
   endfunction

   task automatic send_beat(input logic [63:0] samples, input logic [1:0] ch,
                            input logic typed, input merge_result_type result,
                            input int idle_pct);
      beat_plan_type plan;
      csr_we <= 1'b0;
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      plan.typed  = typed;
      plan.result = result;
      beat_plan_q.push_back(plan);
      req_tvalid <= 1'b1;
      req_tdata  <= samples;
      req_tuser  <= ch;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
   endtask

   task automatic write_csr(input hbm_pkg::csr_index_type idx, input logic [23:0] val);
      req_tvalid <= 1'b0;
      while (results_seen != beats_sent) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         hbm_pkg::CSR_ACTIVE:     cfg_count   = val[2:0];
         hbm_pkg::CSR_GAIN_ONE:   gain_cfg[1] = val;
         hbm_pkg::CSR_GAIN_TWO:   gain_cfg[2] = val;
         hbm_pkg::CSR_GAIN_THREE: gain_cfg[3] = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // result side: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (hold_asked != hold_taken) begin
         hold_taken = hold_asked;
         hold_left  = LONG_HOLD;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      beat_plan_type    plan;
      merge_result_type want;
      bit               moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_tvalid && req_tready) begin
            plan = beat_plan_q.pop_front();
            want = plan.typed ? plan.result : merge_predict(req_tdata, req_tuser);
            merged_expect_q.push_back(want);
            moved = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            results_seen++;
            if (merged_expect_q.size() == 0) begin
               error_count++;
               $display("%0t: result beat with nothing pending, got value %0d flag %0d",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               want = merged_expect_q.pop_front();
               if (rsp_tdata !== want.value) begin
                  error_count++;
                  $display("%0t: merged_value expected %0d actual %0d",
                           $time, want.value, rsp_tdata);
               end
               if (rsp_tuser[0] !== want.flag) begin
                  error_count++;
                  $display("%0t: no_weight expected %0d actual %0d",
                           $time, want.flag, rsp_tuser[0]);
               end
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      step_row_type     row;
      merge_result_type typed_result;
      logic [63:0]      smp;
      bit               dead;
      int               mode;
      int               send_pct;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_csr) begin
            write_csr(row.idx, row.wval);
         end else begin
            typed_result.value = row.value;
            typed_result.flag  = row.flag;
            send_beat(row.samples, row.ch, row.typed, typed_result, 0);
         end
      end

      typed_result = '0;
      for (int p = 0; p < PHASES; p++) begin
         mode = p % 4;
         case (p)
            0: begin
               write_csr(hbm_pkg::CSR_ACTIVE, 24'd4);
               write_csr(hbm_pkg::CSR_GAIN_ONE, hbm_pkg::UNITY_GAIN);
               write_csr(hbm_pkg::CSR_GAIN_TWO, hbm_pkg::UNITY_GAIN);
               write_csr(hbm_pkg::CSR_GAIN_THREE, hbm_pkg::UNITY_GAIN);
            end
            1: begin
               write_csr(hbm_pkg::CSR_ACTIVE, 24'd1);
               write_csr(hbm_pkg::CSR_GAIN_ONE, 24'hFFFFFF);
               write_csr(hbm_pkg::CSR_GAIN_TWO, 24'hFFFFFF);
               write_csr(hbm_pkg::CSR_GAIN_THREE, 24'hFFFFFF);
            end
            2: begin
               write_csr(hbm_pkg::CSR_ACTIVE, 24'd2);
               write_csr(hbm_pkg::CSR_GAIN_ONE, 24'd0);
               write_csr(hbm_pkg::CSR_GAIN_TWO, 24'd0);
               write_csr(hbm_pkg::CSR_GAIN_THREE, 24'd0);
            end
            3: begin
               write_csr(hbm_pkg::CSR_ACTIVE, 24'd3);
               write_csr(hbm_pkg::CSR_GAIN_ONE, 24'($urandom()));
               write_csr(hbm_pkg::CSR_GAIN_TWO, 24'($urandom()));
               write_csr(hbm_pkg::CSR_GAIN_THREE, 24'($urandom()));
            end
            default: begin
               write_csr(hbm_pkg::CSR_ACTIVE, 24'($urandom_range(7)));
               write_csr(hbm_pkg::CSR_GAIN_ONE, pick_gain());
               write_csr(hbm_pkg::CSR_GAIN_TWO, pick_gain());
               write_csr(hbm_pkg::CSR_GAIN_THREE, pick_gain());
            end
         endcase
         send_pct  = (mode == 1) ? 52 : (mode == 3) ? 13 : 0;
         stall_pct = (mode == 2) ? 52 : (mode == 3) ? 13 : 0;
         for (int n = 0; n < PHASE_BEATS; n++) begin
            // no idling on either side for a stretch in each phase
            if (n == PHASE_BEATS / 2) stall_pct = 0;
            if (n == 3 * PHASE_BEATS / 4) stall_pct = (mode == 2) ? 52 : (mode == 3) ? 13 : 0;
            if (p == 4 && n == 60) hold_asked++;
            dead = ($urandom_range(9) == 0);
            for (int b = 0; b < 4; b++) smp[16*b +: 16] = pick_sample(dead);
            send_beat(smp, 2'($urandom_range(3)), 1'b0, typed_result,
                      (n >= PHASE_BEATS / 2 && n < 3 * PHASE_BEATS / 4) ? 0 : send_pct);
         end
      end

      req_tvalid <= 1'b0;
      csr_we     <= 1'b0;
      while (results_seen != beats_sent) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (merged_expect_q.size() != 0) begin
         error_count++;
         $display("%0t: %0d expected results never arrived", $time, merged_expect_q.size());
      end
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/hbm_pkg.sv
hw/rtl/hbm_lane.sv
hw/rtl/hbm_divider.sv
hw/rtl/hdr_bracket_merge.sv
test/tb_top.sv
